[src/nsr_pkg.sv]
// nsr_pkg: shared widths, pipeline constants and the binomial row builder
// for the neighbour subset rank block
// depends on nothing; used by every other file of the block
package nsr_pkg;

  // transaction field widths
  localparam int unsigned NbrW   = 32;
  localparam int unsigned ColW   = 5;
  localparam int unsigned CfgW   = 6;
  localparam int unsigned DegW   = 5;
  localparam int unsigned RankW  = 29;

  // binomial rows are indexed by a count of up to six bits
  localparam int unsigned RowIdxW = 6;
  localparam int unsigned RowLen  = 64;

  // prefix count group size and padded width of the adder tree
  localparam int unsigned GrpSz  = 8;
  localparam int unsigned TreeN  = 64;

  // number of register stages from input to output register
  localparam int unsigned NStg   = 8;

  typedef logic [RankW-1:0] binom_row_t [RowLen];

  // row n of pascal's triangle, kept modulo 2^RankW
  function automatic binom_row_t binom_row(input int unsigned n);
    binom_row_t row;
    for (int k = 0; k < RowLen; k++) begin
      row[k] = '0;
    end
    row[0] = RankW'(1);
    for (int i = 1; i <= int'(n); i++) begin
      for (int k = i; k >= 1; k--) begin
        if (k < RowLen) begin
          row[k] = row[k] + row[k-1];
        end
      end
    end
    return row;
  endfunction

endpackage

[src/nsr_in_if.sv]
// nsr_in_if: input channel of the neighbour subset rank block
// valid/ready handshake with column bits and column index; uses nsr_pkg
interface nsr_in_if;
  logic                         valid;
  logic                         ready;
  logic [nsr_pkg::NbrW-1:0]     neighbor_bits;
  logic [nsr_pkg::ColW-1:0]     column_index;

  modport source (output valid, neighbor_bits, column_index, input ready);
  modport sink   (input valid, neighbor_bits, column_index, output ready);
endinterface

[src/nsr_out_if.sv]
// nsr_out_if: result channel of the neighbour subset rank block
// valid/ready handshake with degree, rank and isolated flag; uses nsr_pkg
interface nsr_out_if;
  logic                         valid;
  logic                         ready;
  logic [nsr_pkg::DegW-1:0]     degree;
  logic [nsr_pkg::RankW-1:0]    subset_rank;
  logic                         isolated;

  modport source (output valid, degree, subset_rank, isolated, input ready);
  modport sink   (input valid, degree, subset_rank, isolated, output ready);
endinterface

[src/nsr_compact.sv]
// nsr_compact: first two pipeline stages; masks bits beyond the graph, drops
// the self bit, then reverses so position 0 is the top compacted variable
// depends on nsr_pkg
module nsr_compact #(
  parameter int unsigned MAX_VARS = 32,
  localparam int unsigned PW = $clog2(MAX_VARS + 1)
) (
  input  logic                        clk_i,
  input  logic [1:0]                  en_i,
  input  logic [PW-1:0]               p_i,
  input  logic [nsr_pkg::NbrW-1:0]    bits_i,
  input  logic [nsr_pkg::ColW-1:0]    col_i,
  output logic [MAX_VARS-1:0]         r_o
);

  localparam int unsigned ExtW = (MAX_VARS > nsr_pkg::NbrW) ? MAX_VARS : nsr_pkg::NbrW;

  logic [ExtW-1:0]     ext;
  logic [MAX_VARS:0]   kept;
  logic [6:0]          p_w;
  logic [6:0]          j_w;
  logic [MAX_VARS-1:0] cmp_d, cmp_q;
  logic [MAX_VARS-1:0] rev;
  logic [6:0]          shamt;
  logic [MAX_VARS-1:0] r_d, r_q;

  // stage one: clamp column index, mask and compact around the self bit
  always_comb begin
    ext = ExtW'(bits_i);
    p_w = 7'(p_i);
    j_w = 7'(col_i);
    if (j_w >= p_w) begin
      j_w = p_w - 7'd1;
    end
    kept = '0;
    for (int k = 0; k < int'(MAX_VARS); k++) begin
      kept[k] = ext[k] & (7'(k) < p_w);
    end
    for (int k = 0; k < int'(MAX_VARS); k++) begin
      cmp_d[k] = (7'(k) < j_w) ? kept[k] : kept[k+1];
    end
  end

  // stage two: reverse and align so bit m is compacted position p-2-m
  always_comb begin
    for (int x = 0; x < int'(MAX_VARS); x++) begin
      rev[x] = cmp_q[MAX_VARS-1-x];
    end
    shamt = 7'(MAX_VARS + 1) - 7'(p_i);
    r_d   = rev >> shamt;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      cmp_q <= cmp_d;
    end
    if (en_i[1]) begin
      r_q <= r_d;
    end
  end

  assign r_o = r_q;

endmodule

[src/nsr_prefix.sv]
// nsr_prefix: stages three and four; running count of set bits from the top
// compacted position down, in groups of eight then with group offsets
// depends on nsr_pkg
module nsr_prefix #(
  parameter int unsigned MAX_VARS = 32,
  localparam int unsigned CntW = $clog2(MAX_VARS + 1)
) (
  input  logic                 clk_i,
  input  logic [1:0]           en_i,
  input  logic [MAX_VARS-1:0]  r_i,
  output logic [MAX_VARS-1:0]  r_o,
  output logic [CntW-1:0]      cnt_o [MAX_VARS],
  output logic [CntW-1:0]      deg_o
);

  localparam int unsigned Grp  = nsr_pkg::GrpSz;
  localparam int unsigned NG   = (MAX_VARS + Grp - 1) / Grp;
  localparam int unsigned PadW = NG * Grp;

  logic [PadW-1:0]     r_pad;
  logic [3:0]          acc;
  logic [3:0]          loc_d [PadW];
  logic [3:0]          loc_q [PadW];
  logic [MAX_VARS-1:0] r3_q, r4_q;
  logic [6:0]          off;
  logic [CntW-1:0]     cnt_d [PadW];
  logic [CntW-1:0]     cnt_q [MAX_VARS];

  // stage three: count within each group of eight
  always_comb begin
    r_pad = PadW'(r_i);
    acc   = '0;
    for (int g = 0; g < int'(NG); g++) begin
      acc = '0;
      for (int i = 0; i < int'(Grp); i++) begin
        acc = acc + {3'b000, r_pad[g*Grp+i]};
        loc_d[g*Grp+i] = acc;
      end
    end
  end

  // stage four: add the totals of the groups above
  always_comb begin
    off = '0;
    for (int g = 0; g < int'(NG); g++) begin
      for (int i = 0; i < int'(Grp); i++) begin
        cnt_d[g*Grp+i] = CntW'(off + 7'(loc_q[g*Grp+i]));
      end
      off = off + 7'(loc_q[g*Grp+Grp-1]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      loc_q <= loc_d;
      r3_q  <= r_i;
    end
    if (en_i[1]) begin
      for (int m = 0; m < int'(MAX_VARS); m++) begin
        cnt_q[m] <= cnt_d[m];
      end
      r4_q <= r3_q;
    end
  end

  assign r_o   = r4_q;
  assign cnt_o = cnt_q;
  // positions beyond the top are clear, so the last running count is the degree
  assign deg_o = cnt_q[MAX_VARS-1];

endmodule

[src/nsr_lanes.sv]
// nsr_lanes: stage five; one lane per reversed position looks up its own
// binomial row, giving the top term or the negated per-neighbour term
// depends on nsr_pkg
module nsr_lanes #(
  parameter int unsigned MAX_VARS = 32,
  localparam int unsigned PW   = $clog2(MAX_VARS + 1),
  localparam int unsigned CntW = $clog2(MAX_VARS + 1)
) (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [PW-1:0]               p_i,
  input  logic [MAX_VARS-1:0]         r_i,
  input  logic [CntW-1:0]             cnt_i [MAX_VARS],
  input  logic [CntW-1:0]             deg_i,
  output logic [nsr_pkg::RankW-1:0]   v_o [nsr_pkg::TreeN],
  output logic [CntW-1:0]             deg_o
);

  logic [CntW-1:0] deg_q;

  for (genvar m = 0; m < nsr_pkg::TreeN; m++) begin : g_lane
    if (m < MAX_VARS) begin : g_used
      localparam nsr_pkg::binom_row_t Row = nsr_pkg::binom_row(m);

      logic                       top;
      logic [CntW-1:0]            k;
      logic [nsr_pkg::RankW-1:0]  c;
      logic [nsr_pkg::RankW-1:0]  v_d, v_q;

      // lane p-1 carries C(p-1, d); neighbour lanes subtract C(m, count)
      assign top = (p_i == PW'(m + 1));
      assign k   = top ? deg_i : cnt_i[m];
      assign c   = Row[nsr_pkg::RowIdxW'(k)];

      always_comb begin
        if (top) begin
          v_d = c;
        end else if (r_i[m]) begin
          v_d = nsr_pkg::RankW'(0) - c;
        end else begin
          v_d = '0;
        end
      end

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          v_q <= v_d;
        end
      end

      assign v_o[m] = v_q;
    end else begin : g_pad
      assign v_o[m] = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      deg_q <= deg_i;
    end
  end

  assign deg_o = deg_q;

endmodule

[src/nsr_sum_tree.sv]
// nsr_sum_tree: stages six to eight; registered four-way adder tree over the
// lane terms, ending in the output register with the isolated gating
// depends on nsr_pkg
module nsr_sum_tree #(
  parameter int unsigned MAX_VARS = 32,
  localparam int unsigned CntW = $clog2(MAX_VARS + 1)
) (
  input  logic                        clk_i,
  input  logic [2:0]                  en_i,
  input  logic [nsr_pkg::RankW-1:0]   v_i [nsr_pkg::TreeN],
  input  logic [CntW-1:0]             deg_i,
  output logic [nsr_pkg::DegW-1:0]    degree_o,
  output logic [nsr_pkg::RankW-1:0]   rank_o,
  output logic                        isolated_o
);

  localparam int unsigned N1 = nsr_pkg::TreeN / 4;
  localparam int unsigned N2 = N1 / 4;

  logic [nsr_pkg::RankW-1:0] s1_d [N1];
  logic [nsr_pkg::RankW-1:0] s1_q [N1];
  logic [nsr_pkg::RankW-1:0] s2_d [N2];
  logic [nsr_pkg::RankW-1:0] s2_q [N2];
  logic [nsr_pkg::RankW-1:0] sum;
  logic [CntW-1:0]           deg6_q, deg7_q;
  logic                      iso;
  logic [nsr_pkg::DegW-1:0]  degree_q;
  logic [nsr_pkg::RankW-1:0] rank_d, rank_q;
  logic                      iso_q;

  // first and second tree levels, modulo 2^29
  always_comb begin
    for (int i = 0; i < int'(N1); i++) begin
      s1_d[i] = v_i[4*i] + v_i[4*i+1] + v_i[4*i+2] + v_i[4*i+3];
    end
    for (int i = 0; i < int'(N2); i++) begin
      s2_d[i] = s1_q[4*i] + s1_q[4*i+1] + s1_q[4*i+2] + s1_q[4*i+3];
    end
  end

  // final level; an empty neighbour set reports rank zero
  always_comb begin
    sum = '0;
    for (int i = 0; i < int'(N2); i++) begin
      sum = sum + s2_q[i];
    end
    iso    = (deg7_q == '0);
    rank_d = iso ? '0 : sum;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      s1_q   <= s1_d;
      deg6_q <= deg_i;
    end
    if (en_i[1]) begin
      s2_q   <= s2_d;
      deg7_q <= deg6_q;
    end
    if (en_i[2]) begin
      rank_q   <= rank_d;
      degree_q <= nsr_pkg::DegW'(deg7_q);
      iso_q    <= iso;
    end
  end

  assign degree_o   = degree_q;
  assign rank_o     = rank_q;
  assign isolated_o = iso_q;

endmodule

[src/neighbor_subset_rank.sv]
// neighbor_subset_rank: degree and lexicographic subset rank of one column
// throughput: one transaction per cycle while out_o is ready, set by the
// eight-stage pipeline; each stage holds one item and refills as soon as
// its successor moves on
// reset: pipeline valid bits cleared, num_vars back to 32 (capped at MAX_VARS)
module neighbor_subset_rank #(
  parameter int unsigned MAX_VARS = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [nsr_pkg::CfgW-1:0]    cfg_data_i,
  nsr_in_if.sink                      in_i,
  nsr_out_if.source                   out_o
);

  localparam int unsigned PW     = $clog2(MAX_VARS + 1);
  localparam int unsigned CntW   = $clog2(MAX_VARS + 1);
  localparam int unsigned PReset = (MAX_VARS < 32) ? MAX_VARS : 32;

  logic [PW-1:0]                 p_d, p_q;
  logic [nsr_pkg::NStg-1:0]      vld_q;
  logic [nsr_pkg::NStg-1:0]      adv;
  logic [MAX_VARS-1:0]           r_s2, r_s4;
  logic [CntW-1:0]               cnt_s4 [MAX_VARS];
  logic [CntW-1:0]               deg_s4, deg_s5;
  logic [nsr_pkg::RankW-1:0]     lane_v [nsr_pkg::TreeN];

  // graph size register, clamped on write to the supported range
  always_comb begin
    if (cfg_data_i < nsr_pkg::CfgW'(2)) begin
      p_d = PW'(2);
    end else if (7'(cfg_data_i) > 7'(MAX_VARS)) begin
      p_d = PW'(MAX_VARS);
    end else begin
      p_d = PW'(cfg_data_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_q <= PW'(PReset);
    end else if (cfg_we_i) begin
      p_q <= p_d;
    end
  end

  // a stage advances when it is empty or the stage after it advances
  always_comb begin
    adv[nsr_pkg::NStg-1] = !vld_q[nsr_pkg::NStg-1] || out_o.ready;
    for (int k = nsr_pkg::NStg - 2; k >= 0; k--) begin
      adv[k] = !vld_q[k] || adv[k+1];
    end
  end

  // valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) begin
        vld_q[0] <= in_i.valid;
      end
      for (int k = 1; k < nsr_pkg::NStg; k++) begin
        if (adv[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  assign in_i.ready  = adv[0];
  assign out_o.valid = vld_q[nsr_pkg::NStg-1];

  // compaction and reversal
  nsr_compact #(.MAX_VARS(MAX_VARS)) u_compact (
    .clk_i  (clk_i),
    .en_i   (adv[1:0]),
    .p_i    (p_q),
    .bits_i (in_i.neighbor_bits),
    .col_i  (in_i.column_index),
    .r_o    (r_s2)
  );

  // running neighbour counts
  nsr_prefix #(.MAX_VARS(MAX_VARS)) u_prefix (
    .clk_i (clk_i),
    .en_i  (adv[3:2]),
    .r_i   (r_s2),
    .r_o   (r_s4),
    .cnt_o (cnt_s4),
    .deg_o (deg_s4)
  );

  // per-position binomial terms
  nsr_lanes #(.MAX_VARS(MAX_VARS)) u_lanes (
    .clk_i (clk_i),
    .en_i  (adv[4]),
    .p_i   (p_q),
    .r_i   (r_s4),
    .cnt_i (cnt_s4),
    .deg_i (deg_s4),
    .v_o   (lane_v),
    .deg_o (deg_s5)
  );

  // term sum and output register
  nsr_sum_tree #(.MAX_VARS(MAX_VARS)) u_sum_tree (
    .clk_i      (clk_i),
    .en_i       (adv[7:5]),
    .v_i        (lane_v),
    .deg_i      (deg_s5),
    .degree_o   (out_o.degree),
    .rank_o     (out_o.subset_rank),
    .isolated_o (out_o.isolated)
  );

endmodule
